[sv/leb_pkg.sv]
`timescale 1ns / 1ps
package leb_pkg;

  localparam int LINE_LENGTH = 32;
  localparam int CUR_W       = $clog2(LINE_LENGTH + 1);
  localparam int CNT_W       = $clog2(LINE_LENGTH);
  localparam int CHAR_W      = 8;
  localparam int OUT_CUR_W   = 6;

  localparam logic [CHAR_W-1:0] KEY_LEFT      = 8'd75;
  localparam logic [CHAR_W-1:0] KEY_RIGHT     = 8'd77;
  localparam logic [CHAR_W-1:0] KEY_END       = 8'd79;
  localparam logic [CHAR_W-1:0] KEY_HOME      = 8'd71;
  localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] KEY_ENTER     = 8'd13;
  localparam logic [CHAR_W-1:0] FILL_CHAR     = 8'h20;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_LINE   = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [CHAR_W-1:0] key;
  } cell_ctrl_t;

  function automatic logic [OUT_CUR_W-1:0] cur_out(input logic [CUR_W-1:0] c);
    logic [CUR_W+OUT_CUR_W-1:0] t;
    t = {{OUT_CUR_W{1'b0}}, c};
    return t[OUT_CUR_W-1:0];
  endfunction

endpackage

[sv/leb_if.sv]
`timescale 1ns / 1ps
interface leb_in_if;
  import leb_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] key_code;
  logic              extended;

  modport source (output valid, key_code, extended, input ready);
  modport sink   (input valid, key_code, extended, output ready);
endinterface

interface leb_out_if;
  import leb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [CHAR_W-1:0]    character;
  logic [OUT_CUR_W-1:0] cursor;
  logic                 last;

  modport source (output valid, kind, character, cursor, last, input ready);
  modport sink   (input valid, kind, character, cursor, last, output ready);
endinterface

[sv/leb_cell.sv]
`timescale 1ns / 1ps
module leb_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  leb_pkg::cell_ctrl_t        ctrl,
  input  logic                       at_cur,
  input  logic                       past_cur,
  input  logic                       past_del,
  input  logic [leb_pkg::CHAR_W-1:0] from_left,
  input  logic [leb_pkg::CHAR_W-1:0] from_right,
  output logic [leb_pkg::CHAR_W-1:0] cell_char
);
  import leb_pkg::*;

  logic [CHAR_W-1:0] char_r;
  logic [CHAR_W-1:0] char_nxt;

  always_comb begin
    char_nxt = char_r;
    case (ctrl.op)
      CELL_INS: begin
        if (past_cur) char_nxt = from_left;
        else if (at_cur) char_nxt = ctrl.key;
      end
      CELL_DEL: begin
        if (past_del) char_nxt = from_right;
      end
      CELL_ROT: char_nxt = from_right;
      default:  char_nxt = char_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_r <= FILL_CHAR;
    end else begin
      char_r <= char_nxt;
    end
  end

  assign cell_char = char_r;

endmodule

[sv/line_edit_buffer.sv]
`timescale 1ns / 1ps
// Channel | Dir | Payload                               | Handshake
// in_ch   | in  | key_code[7:0], extended               | valid/ready
// out_ch  | out | kind, character[7:0], cursor[5:0], last | valid/ready
//
// An edit key yields one status request from the output register.
// Enter is accepted, then the cell row rotates once, one character per cycle while the
// output register is not stalled.
// No key is accepted while the line streams or the output register is full and stalled.
// Synchronous active-low reset loads every cell with a space and the cursor with 0.
// A stalled output holds the row and the stream counter.
module line_edit_buffer (
  input  logic clk,
  input  logic rst_n,
  leb_in_if.sink    in_ch,
  leb_out_if.source out_ch
);
  import leb_pkg::*;

  typedef enum logic {ST_IDLE, ST_STREAM} state_t;

  state_t                state_r;
  logic [CUR_W-1:0]      cur_r, cur_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic                  out_valid_r;
  logic                  out_kind_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic [OUT_CUR_W-1:0]  out_cur_r;
  logic                  out_last_r;

  logic                  in_fire, out_free, stream_fire, is_enter, cnt_end;
  cell_ctrl_t            ctrl;
  logic [CHAR_W-1:0]     cells [LINE_LENGTH];
  logic [CHAR_W-1:0]     tail_in;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign stream_fire = (state_r == ST_STREAM) && out_free;
  assign is_enter    = !in_ch.extended && (in_ch.key_code == KEY_ENTER);
  assign cnt_end     = (cnt_r == CNT_W'(LINE_LENGTH - 1));

  always_comb begin
    cur_nxt  = cur_r;
    ctrl.op  = CELL_HOLD;
    ctrl.key = in_ch.key_code;
    if (in_fire) begin
      if (in_ch.extended) begin
        unique case (in_ch.key_code)
          KEY_LEFT:  if (cur_r != '0) cur_nxt = cur_r - CUR_W'(1);
          KEY_RIGHT: if (cur_r < CUR_W'(LINE_LENGTH - 1)) cur_nxt = cur_r + CUR_W'(1);
          KEY_END:   cur_nxt = CUR_W'(LINE_LENGTH - 1);
          KEY_HOME:  cur_nxt = '0;
          default:   cur_nxt = cur_r;
        endcase
      end else if (is_enter) begin
        cur_nxt = cur_r;
      end else if (in_ch.key_code == KEY_BACKSPACE) begin
        if (cur_r != '0) begin
          cur_nxt = cur_r - CUR_W'(1);
          ctrl.op = CELL_DEL;
        end
      end else if (cur_r < CUR_W'(LINE_LENGTH)) begin
        cur_nxt = cur_r + CUR_W'(1);
        ctrl.op = CELL_INS;
      end
    end else if (stream_fire) begin
      ctrl.op = CELL_ROT;
    end
  end

  assign tail_in = (ctrl.op == CELL_ROT) ? cells[0] : FILL_CHAR;

  for (genvar i = 0; i < LINE_LENGTH; i++) begin : g_cell
    localparam logic [CUR_W-1:0] IDX = CUR_W'(i);
    logic [CHAR_W-1:0] left_c, right_c;
    if (i == 0) begin : g_first
      assign left_c = FILL_CHAR;
    end else begin : g_mid_l
      assign left_c = cells[i-1];
    end
    if (i == LINE_LENGTH - 1) begin : g_lastc
      assign right_c = tail_in;
    end else begin : g_mid_r
      assign right_c = cells[i+1];
    end
    leb_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .at_cur     (IDX == cur_r),
      .past_cur   (IDX > cur_r),
      .past_del   (cur_r <= IDX + CUR_W'(1)),
      .from_left  (left_c),
      .from_right (right_c),
      .cell_char  (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r <= cur_nxt;
      if (in_fire) begin
        if (is_enter) begin
          state_r <= ST_STREAM;
          cnt_r   <= '0;
          out_valid_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b1;
          out_kind_r  <= KIND_STATUS;
          out_char_r  <= '0;
          out_cur_r   <= cur_out(cur_nxt);
          out_last_r  <= 1'b1;
        end
      end else if (stream_fire) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= KIND_LINE;
        out_char_r  <= cells[0];
        out_cur_r   <= cur_out(cur_r);
        out_last_r  <= cnt_end;
        cnt_r       <= cnt_r + CNT_W'(1);
        if (cnt_end) state_r <= ST_IDLE;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_kind_r;
  assign out_ch.character = out_char_r;
  assign out_ch.cursor    = out_cur_r;
  assign out_ch.last      = out_last_r;

`ifndef ASSERT_OFF
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == ST_IDLE)
    else $error("key accepted during line stream");
  a_enter_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_enter) |=> (state_r == ST_STREAM && cnt_r == '0))
    else $error("enter did not start stream");
  a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STREAM |=> $stable(cur_r))
    else $error("cursor moved during stream");
  a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
    (stream_fire && cnt_end) |=> (state_r == ST_IDLE && out_ch.last && out_ch.valid))
    else $error("stream did not end on last character");
`endif

endmodule
